// ===== design/bpc_pkg.sv =====
package bpc_pkg;

    localparam int DIV_STAGES = 32;
    localparam int DVD_W      = 32;
    localparam int DVS_W      = 20;
    localparam int TEMP_LAT   = DIV_STAGES + 6;
    localparam int PRESS_LAT  = DIV_STAGES + 14;
    localparam int CFG_IDX_W  = 3;

    localparam logic signed [15:0] TEMP_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] TEMP_MIN  = 16'sh8000;
    localparam logic [19:0]        PRESS_MAX = 20'hFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4,
        CFG_OSS     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [19:0]        pressure_pa;
        logic               divide_error;
    } t_out_beat;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } t_coeffs;

    typedef struct packed {
        logic               valid;
        logic [18:0]        up;
        logic signed [28:0] b5;
        logic signed [15:0] temp;
        logic               dz;
    } t_temp_res;

endpackage

// ===== design/bpc_div.sv =====
module bpc_div
    import bpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient
);

    logic [DVS_W-1:0] r_rem [DIV_STAGES];
    logic [DVD_W-1:0] r_num [DIV_STAGES];
    logic [DVS_W-1:0] r_dvs [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DVS_W-1:0] w_rem_in;
        logic [DVD_W-1:0] w_num_in;
        logic [DVS_W-1:0] w_dvs_in;
        logic [DVS_W:0]   w_part;
        logic [DVS_W+1:0] w_diff;
        logic             w_ge;
        logic [DVS_W-1:0] n_rem;
        logic [DVD_W-1:0] n_num;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_num_in = i_dividend;
            assign w_dvs_in = i_divisor;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_num_in = r_num[k-1];
            assign w_dvs_in = r_dvs[k-1];
        end

        always_comb begin
            w_part = {w_rem_in, w_num_in[DVD_W-1]};
            w_diff = {1'b0, w_part} - {2'b00, w_dvs_in};
            w_ge   = !w_diff[DVS_W+1];
            n_rem  = w_ge ? w_diff[DVS_W-1:0] : w_part[DVS_W-1:0];
            n_num  = {w_num_in[DVD_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_num[k] <= n_num;
                r_dvs[k] <= w_dvs_in;
            end
        end
    end

    assign o_quotient = r_num[DIV_STAGES-1];

endmodule

// ===== design/bpc_temp.sv =====
module bpc_temp
    import bpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_in_beat  i_beat,
    input  t_coeffs   i_coeffs,
    output t_temp_res o_res
);

    typedef struct packed {
        logic signed [19:0] x1;
        logic               neg;
        logic               dz;
        logic               mcneg;
    } t_div_sb;

    logic [TEMP_LAT-1:0] r_vld;
    logic [18:0]         r_up [TEMP_LAT];

    logic signed [17:0] r_t1_diff, n_t1_diff;
    logic signed [34:0] r_t2_prod, n_t2_prod;
    logic signed [19:0] r_t3_x1, n_t3_x1;
    logic signed [20:0] w_den;
    logic [16:0]        w_mc_mag;
    logic [DVD_W-1:0]   r_t4_dvd, n_t4_dvd;
    logic [DVS_W-1:0]   r_t4_dvs, n_t4_dvs;
    t_div_sb            r_t4_sb, n_t4_sb;
    t_div_sb            r_dsb [DIV_STAGES];
    logic [DVD_W-1:0]   w_quot;
    logic signed [28:0] w_x2;
    logic signed [28:0] r_t5_b5, n_t5_b5;
    t_div_sb            r_t5_sb;
    logic signed [25:0] w_t;
    logic signed [15:0] r_t6_temp, n_t6_temp;
    logic signed [28:0] r_t6_b5;
    logic               r_t6_dz;

    always_comb begin
        n_t1_diff = $signed({2'b00, i_beat.raw_temperature}) - $signed({2'b00, i_coeffs.ac6});
        n_t2_prod = r_t1_diff * $signed({1'b0, i_coeffs.ac5});
        n_t3_x1   = 20'(r_t2_prod >>> 15);

        w_den    = 21'(r_t3_x1) + 21'(i_coeffs.md);
        w_mc_mag = i_coeffs.mc[15] ? 17'(-17'(i_coeffs.mc)) : 17'(i_coeffs.mc);
        n_t4_dvd = {4'b0000, w_mc_mag, 11'b0};
        n_t4_dvs = w_den[20] ? 20'(-w_den) : 20'(w_den);
        n_t4_sb.x1    = r_t3_x1;
        n_t4_sb.neg   = w_den[20] ^ i_coeffs.mc[15];
        n_t4_sb.dz    = (w_den == '0);
        n_t4_sb.mcneg = i_coeffs.mc[15];

        w_x2    = r_dsb[DIV_STAGES-1].neg ? -29'(w_quot[27:0]) : 29'(w_quot[27:0]);
        n_t5_b5 = 29'(r_dsb[DIV_STAGES-1].x1) + w_x2;

        w_t = 26'((30'(r_t5_b5) + 30'sd8) >>> 4);
        priority if (r_t5_sb.dz) begin
            n_t6_temp = r_t5_sb.mcneg ? TEMP_MIN : TEMP_MAX;
        end else if (w_t > 26'(TEMP_MAX)) begin
            n_t6_temp = TEMP_MAX;
        end else if (w_t < 26'(TEMP_MIN)) begin
            n_t6_temp = TEMP_MIN;
        end else begin
            n_t6_temp = 16'(w_t);
        end
    end

    bpc_div u_div (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (r_t4_dvd),
        .i_divisor  (r_t4_dvs),
        .o_quotient (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[TEMP_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_up[0] <= i_beat.raw_pressure;
            for (int k = 1; k < TEMP_LAT; k++) begin
                r_up[k] <= r_up[k-1];
            end
            r_dsb[0] <= r_t4_sb;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_dsb[k] <= r_dsb[k-1];
            end
            r_t1_diff <= n_t1_diff;
            r_t2_prod <= n_t2_prod;
            r_t3_x1   <= n_t3_x1;
            r_t4_dvd  <= n_t4_dvd;
            r_t4_dvs  <= n_t4_dvs;
            r_t4_sb   <= n_t4_sb;
            r_t5_b5   <= n_t5_b5;
            r_t5_sb   <= r_dsb[DIV_STAGES-1];
            r_t6_temp <= n_t6_temp;
            r_t6_b5   <= r_t5_b5;
            r_t6_dz   <= r_t5_sb.dz;
        end
    end

    assign o_res.valid = r_vld[TEMP_LAT-1];
    assign o_res.up    = r_up[TEMP_LAT-1];
    assign o_res.b5    = r_t6_b5;
    assign o_res.temp  = r_t6_temp;
    assign o_res.dz    = r_t6_dz;

endmodule

// ===== design/bpc_press.sv =====
module bpc_press
    import bpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_temp_res i_res,
    input  t_coeffs   i_coeffs,
    output logic      o_valid,
    output t_out_beat o_beat
);

    typedef struct packed {
        logic [18:0]        up;
        logic signed [15:0] temp;
        logic               dz;
    } t_press_sb;

    typedef struct packed {
        logic dbl;
        logic bz;
    } t_pdiv_sb;

    logic [PRESS_LAT-1:0] r_vld;
    t_press_sb            r_sb [PRESS_LAT-1];
    t_press_sb            w_sb_in;

    logic signed [29:0] r_p1_b6, n_p1_b6;
    logic signed [59:0] r_p2_sq, n_p2_sq;
    logic signed [45:0] r_p2_ac2b6, n_p2_ac2b6;
    logic signed [45:0] r_p2_ac3b6, n_p2_ac3b6;
    logic [41:0]        w_sq;
    logic signed [58:0] r_p3_b2sq, n_p3_b2sq;
    logic signed [58:0] r_p3_b1sq, n_p3_b1sq;
    logic signed [34:0] r_p3_x2a, n_p3_x2a;
    logic signed [32:0] r_p3_x1c, n_p3_x1c;
    logic signed [48:0] r_p4_x3a, n_p4_x3a;
    logic signed [44:0] r_p4_x3cs, n_p4_x3cs;
    logic signed [53:0] w_p5_s;
    logic signed [53:0] r_p5_w, n_p5_w;
    logic [31:0]        r_p5_t32, n_p5_t32;
    logic signed [53:0] w_p6_adj;
    logic [31:0]        r_p6_b3, n_p6_b3;
    logic [31:0]        r_p6_b4f, n_p6_b4f;
    logic [31:0]        r_p7_diff, n_p7_diff;
    logic [16:0]        r_p7_b4;
    logic [15:0]        w_scale;
    logic [31:0]        r_p8_b7, n_p8_b7;
    logic [16:0]        r_p8_b4;
    logic [DVD_W-1:0]   r_p9_dvd, n_p9_dvd;
    logic [DVS_W-1:0]   r_p9_dvs;
    t_pdiv_sb           r_p9_sb, n_p9_sb;
    t_pdiv_sb           r_pdsb [DIV_STAGES];
    logic [DVD_W-1:0]   w_quot;
    logic [32:0]        r_p10_p, n_p10_p;
    logic               r_p10_bz;
    logic [24:0]        w_s8;
    logic [49:0]        r_p11_s2, n_p11_s2;
    logic signed [49:0] r_p11_m7, n_p11_m7;
    logic [32:0]        r_p11_p;
    logic               r_p11_bz;
    logic [47:0]        r_p12_x1, n_p12_x1;
    logic signed [33:0] r_p12_x2, n_p12_x2;
    logic [32:0]        r_p12_p;
    logic               r_p12_bz;
    logic signed [49:0] r_p13_e, n_p13_e;
    logic [32:0]        r_p13_p;
    logic               r_p13_bz;
    logic signed [50:0] w_p2;
    logic [19:0]        w_psat;
    t_out_beat          r_p14_beat, n_p14_beat;

    always_comb begin
        w_sb_in.up   = i_res.up;
        w_sb_in.temp = i_res.temp;
        w_sb_in.dz   = i_res.dz;

        n_p1_b6 = 30'(i_res.b5) - 30'sd4000;

        n_p2_sq    = r_p1_b6 * r_p1_b6;
        n_p2_ac2b6 = i_coeffs.ac2 * r_p1_b6;
        n_p2_ac3b6 = i_coeffs.ac3 * r_p1_b6;

        w_sq      = r_p2_sq[53:12];
        n_p3_b2sq = i_coeffs.b2 * $signed({1'b0, w_sq});
        n_p3_b1sq = i_coeffs.b1 * $signed({1'b0, w_sq});
        n_p3_x2a  = 35'(r_p2_ac2b6 >>> 11);
        n_p3_x1c  = 33'(r_p2_ac3b6 >>> 13);

        n_p4_x3a  = 49'(r_p3_b2sq >>> 11) + 49'(r_p3_x2a);
        n_p4_x3cs = 45'(r_p3_b1sq >>> 16) + 45'(r_p3_x1c) + 45'sd2;

        w_p5_s   = (54'(i_coeffs.ac1) <<< 2) + 54'(r_p4_x3a);
        n_p5_w   = (w_p5_s <<< i_coeffs.oss) + 54'sd2;
        n_p5_t32 = 32'(r_p4_x3cs >>> 2) + 32'd32768;

        w_p6_adj = r_p5_w + (r_p5_w[53] ? 54'sd3 : 54'sd0);
        n_p6_b3  = w_p6_adj[33:2];
        n_p6_b4f = 32'(i_coeffs.ac4 * r_p5_t32);

        n_p7_diff = {13'b0, r_sb[5].up} - r_p6_b3;

        w_scale = 16'(16'd50000 >> i_coeffs.oss);
        n_p8_b7 = r_p7_diff * {16'b0, w_scale};

        n_p9_dvd    = r_p8_b7[31] ? r_p8_b7 : {r_p8_b7[30:0], 1'b0};
        n_p9_sb.dbl = r_p8_b7[31];
        n_p9_sb.bz  = (r_p8_b4 == '0);

        n_p10_p = r_pdsb[DIV_STAGES-1].dbl ? {w_quot, 1'b0} : {1'b0, w_quot};

        w_s8     = r_p10_p[32:8];
        n_p11_s2 = w_s8 * w_s8;
        n_p11_m7 = $signed({1'b0, r_p10_p}) * -16'sd7357;

        n_p12_x1 = 48'((64'(r_p11_s2) * 64'd3038) >> 16);
        n_p12_x2 = 34'(r_p11_m7 >>> 16);

        n_p13_e = $signed({2'b00, r_p12_x1}) + 50'(r_p12_x2) + 50'sd3791;

        w_p2 = $signed({18'b0, r_p13_p}) + 51'(r_p13_e >>> 4);
        priority if (w_p2 < 51'sd0) begin
            w_psat = '0;
        end else if (w_p2 > $signed({31'b0, PRESS_MAX})) begin
            w_psat = PRESS_MAX;
        end else begin
            w_psat = w_p2[19:0];
        end

        n_p14_beat.temperature_tenths = r_sb[PRESS_LAT-2].temp;
        n_p14_beat.divide_error       = r_sb[PRESS_LAT-2].dz | r_p13_bz;
        n_p14_beat.pressure_pa        = n_p14_beat.divide_error ? PRESS_MAX : w_psat;
    end

    bpc_div u_div (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (r_p9_dvd),
        .i_divisor  (r_p9_dvs),
        .o_quotient (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[PRESS_LAT-2:0], i_res.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= w_sb_in;
            for (int k = 1; k < PRESS_LAT - 1; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
            r_pdsb[0] <= r_p9_sb;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_pdsb[k] <= r_pdsb[k-1];
            end
            r_p1_b6    <= n_p1_b6;
            r_p2_sq    <= n_p2_sq;
            r_p2_ac2b6 <= n_p2_ac2b6;
            r_p2_ac3b6 <= n_p2_ac3b6;
            r_p3_b2sq  <= n_p3_b2sq;
            r_p3_b1sq  <= n_p3_b1sq;
            r_p3_x2a   <= n_p3_x2a;
            r_p3_x1c   <= n_p3_x1c;
            r_p4_x3a   <= n_p4_x3a;
            r_p4_x3cs  <= n_p4_x3cs;
            r_p5_w     <= n_p5_w;
            r_p5_t32   <= n_p5_t32;
            r_p6_b3    <= n_p6_b3;
            r_p6_b4f   <= n_p6_b4f;
            r_p7_diff  <= n_p7_diff;
            r_p7_b4    <= r_p6_b4f[31:15];
            r_p8_b7    <= n_p8_b7;
            r_p8_b4    <= r_p7_b4;
            r_p9_dvd   <= n_p9_dvd;
            r_p9_dvs   <= {3'b000, r_p8_b4};
            r_p9_sb    <= n_p9_sb;
            r_p10_p    <= n_p10_p;
            r_p10_bz   <= r_pdsb[DIV_STAGES-1].bz;
            r_p11_s2   <= n_p11_s2;
            r_p11_m7   <= n_p11_m7;
            r_p11_p    <= r_p10_p;
            r_p11_bz   <= r_p10_bz;
            r_p12_x1   <= n_p12_x1;
            r_p12_x2   <= n_p12_x2;
            r_p12_p    <= r_p11_p;
            r_p12_bz   <= r_p11_bz;
            r_p13_e    <= n_p13_e;
            r_p13_p    <= r_p12_p;
            r_p13_bz   <= r_p12_bz;
            r_p14_beat <= n_p14_beat;
        end
    end

    assign o_valid = r_vld[PRESS_LAT-1];
    assign o_beat  = r_p14_beat;

endmodule

// ===== design/barometric_pressure_compensation.sv =====
// An accepted beat goes through the temperature pipeline, then the pressure pipeline.
// Throughput: one beat per cycle unless the output stalls; each of the two 32-stage
// restoring dividers retires one quotient bit per stage, so neither limits the rate.
// Output backpressure stalls the whole pipeline in place; nothing is dropped.
// Reset (synchronous, active low) clears all valid bits and all coefficients to zero.
module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_coeffs   r_coeffs, n_coeffs;
    t_temp_res w_temp;
    logic      w_adv;

    assign w_adv       = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_coeffs = r_coeffs;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_AC1_AC2: begin
                    n_coeffs.ac1 = i_cfg_data[31:16];
                    n_coeffs.ac2 = i_cfg_data[15:0];
                end
                CFG_AC3_AC4: begin
                    n_coeffs.ac3 = i_cfg_data[31:16];
                    n_coeffs.ac4 = i_cfg_data[15:0];
                end
                CFG_AC5_AC6: begin
                    n_coeffs.ac5 = i_cfg_data[31:16];
                    n_coeffs.ac6 = i_cfg_data[15:0];
                end
                CFG_B1_B2: begin
                    n_coeffs.b1 = i_cfg_data[31:16];
                    n_coeffs.b2 = i_cfg_data[15:0];
                end
                CFG_MC_MD: begin
                    n_coeffs.mc = i_cfg_data[31:16];
                    n_coeffs.md = i_cfg_data[15:0];
                end
                CFG_OSS: begin
                    n_coeffs.oss = i_cfg_data[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else begin
            r_coeffs <= n_coeffs;
        end
    end

    bpc_temp u_temp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (i_in_valid),
        .i_beat   (i_in_data),
        .i_coeffs (r_coeffs),
        .o_res    (w_temp)
    );

    bpc_press u_press (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_res    (w_temp),
        .i_coeffs (r_coeffs),
        .o_valid  (o_out_valid),
        .o_beat   (o_out_data)
    );

    a_err_press_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.divide_error |-> o_out_data.pressure_pa == PRESS_MAX)
        else $error("divide error without saturated pressure");

    a_dz_temp_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_temp.valid && w_temp.dz |-> w_temp.temp == TEMP_MAX || w_temp.temp == TEMP_MIN)
        else $error("temperature divisor zero without saturated temperature");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !w_temp.valid)
        else $error("valid beat after reset");

endmodule

// ===== dv/barometric_pressure_compensation_tb.sv =====
module barometric_pressure_compensation_tb;
    import bpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_beat             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_beat            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    t_coeffs   cal;
    t_out_beat readings_due[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        fail_cnt = 0;
    int        cycle_cnt = 0;

    barometric_pressure_compensation dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic t_out_beat compensate(t_coeffs c, t_in_beat b);
        longint ut, up, ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
        longint x1, x2, x3, den, b5, b6, b3, t, p, sq, pq;
        logic [31:0] w, b4, b7;
        t_out_beat r;
        ut  = longint'(b.raw_temperature);
        up  = longint'(b.raw_pressure);
        ac1 = longint'($signed(c.ac1));
        ac2 = longint'($signed(c.ac2));
        ac3 = longint'($signed(c.ac3));
        ac5 = longint'(c.ac5);
        ac6 = longint'(c.ac6);
        b1  = longint'($signed(c.b1));
        b2  = longint'($signed(c.b2));
        mc  = longint'($signed(c.mc));
        md  = longint'($signed(c.md));
        r = '0;
        x1 = ((ut - ac6) * ac5) >>> 15;
        den = x1 + md;
        if (den == 0) begin
            r.temperature_tenths = (mc >= 0) ? TEMP_MAX : TEMP_MIN;
            r.pressure_pa = PRESS_MAX;
            r.divide_error = 1'b1;
            return r;
        end
        x2 = (mc * 2048) / den;
        b5 = x1 + x2;
        t = (b5 + 8) >>> 4;
        if (t > longint'(TEMP_MAX)) t = longint'(TEMP_MAX);
        if (t < longint'(TEMP_MIN)) t = longint'(TEMP_MIN);
        r.temperature_tenths = t[15:0];
        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = ((ac1 * 4 + x3) * (longint'(1) << c.oss) + 2) / 4;
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        w = 32'(x3 + 32768);
        b4 = (32'(c.ac4) * w) >> 15;
        if (b4 == 0) begin
            r.pressure_pa = PRESS_MAX;
            r.divide_error = 1'b1;
            return r;
        end
        w = 32'(up - b3);
        b7 = w * (32'd50000 >> c.oss);
        if (b7 < 32'h8000_0000) p = (longint'(b7) * 2) / longint'(b4);
        else p = (longint'(b7) / longint'(b4)) * 2;
        pq = p >>> 8;
        x1 = (pq * pq * 3038) >>> 16;
        x2 = (-7357 * p) >>> 16;
        p = p + ((x1 + x2 + 3791) >>> 4);
        if (p < 0) p = 0;
        if (p > longint'(PRESS_MAX)) p = longint'(PRESS_MAX);
        r.pressure_pa = p[19:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("barometric_pressure_compensation verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat due;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (readings_due.size() == 0) begin
                    $error("unexpected output beat %p", o_out_data);
                    fail_cnt++;
                end else begin
                    due = readings_due.pop_front();
                    if (o_out_data.temperature_tenths !== due.temperature_tenths) begin
                        $error("temperature_tenths exp %0d got %0d",
                               due.temperature_tenths, o_out_data.temperature_tenths);
                        fail_cnt++;
                    end
                    if (o_out_data.pressure_pa !== due.pressure_pa) begin
                        $error("pressure_pa exp %0d got %0d",
                               due.pressure_pa, o_out_data.pressure_pa);
                        fail_cnt++;
                    end
                    if (o_out_data.divide_error !== due.divide_error) begin
                        $error("divide_error exp %0b got %0b",
                               due.divide_error, o_out_data.divide_error);
                        fail_cnt++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_sample(logic [15:0] ut, logic [18:0] up);
        t_in_beat b;
        b.raw_temperature = ut;
        b.raw_pressure = up;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (!o_in_ready);
        readings_due.push_back(compensate(cal, b));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_cal(t_coeffs c);
        drain();
        cfg_beat(CFG_AC1_AC2, {c.ac1, c.ac2});
        cfg_beat(CFG_AC3_AC4, {c.ac3, c.ac4});
        cfg_beat(CFG_AC5_AC6, {c.ac5, c.ac6});
        cfg_beat(CFG_B1_B2, {c.b1, c.b2});
        cfg_beat(CFG_MC_MD, {c.mc, c.md});
        cfg_beat(CFG_OSS, {30'h3FFF_FFFF, c.oss});
        cfg_beat(CFG_SPARE_LO, $urandom());
        cfg_beat(CFG_SPARE_HI, $urandom());
        i_cfg_valid <= 1'b0;
        cal = c;
    endtask

    function automatic t_coeffs typical_cal(logic [1:0] oss, int jitter);
        t_coeffs c;
        c.ac1 = 16'(408 + $urandom_range(2 * jitter) - jitter);
        c.ac2 = 16'(-72 + $urandom_range(2 * jitter) - jitter);
        c.ac3 = 16'(-14383 + $urandom_range(2 * jitter) - jitter);
        c.ac4 = 16'(32741 + $urandom_range(2 * jitter) - jitter);
        c.ac5 = 16'(32757 + $urandom_range(2 * jitter) - jitter);
        c.ac6 = 16'(23153 + $urandom_range(2 * jitter) - jitter);
        c.b1  = 16'(6190 + $urandom_range(2 * jitter) - jitter);
        c.b2  = 16'(4 + $urandom_range(2 * jitter) - jitter);
        c.mc  = 16'(-8711 + $urandom_range(2 * jitter) - jitter);
        c.md  = 16'(2868 + $urandom_range(2 * jitter) - jitter);
        c.oss = oss;
        return c;
    endfunction

    function automatic t_coeffs random_cal();
        t_coeffs c;
        logic [191:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        c = raw[$bits(t_coeffs)-1:0];
        return c;
    endfunction

    task automatic send_typical();
        logic [18:0] up;
        up = 19'($urandom_range(15000, 45000) << cal.oss);
        send_sample(16'($urandom_range(20000, 36000)), up);
    endtask

    task automatic test_reset_cal();
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'd27898, 19'd23843);
    endtask

    task automatic test_typical_oss();
        t_coeffs c;
        for (int o = 0; o < 4; o++) begin
            c = typical_cal(2'(o), 0);
            load_cal(c);
            send_sample(16'd27898, 19'(23843 << o));
            send_sample(16'd0, 19'd0);
            send_sample(16'hFFFF, 19'h7FFFF);
        end
    endtask

    task automatic test_extreme_cal();
        load_cal('1);
        send_sample(16'd0, 19'h7FFFF);
        send_sample(16'hFFFF, 19'd0);
        load_cal(t_coeffs'({{5{32'h8000_8000}}, 2'b11}));
        send_sample(16'd0, 19'h7FFFF);
        send_sample(16'hFFFF, 19'h55555);
        load_cal(t_coeffs'({{5{32'h7FFF_7FFF}}, 2'b10}));
        send_sample(16'h8000, 19'h2AAAA);
        send_sample(16'hFFFF, 19'h7FFFF);
    endtask

    task automatic test_divide_by_zero();
        t_coeffs c;
        c = typical_cal(2'd0, 0);
        c.ac5 = '0;
        c.md = '0;
        load_cal(c);
        send_sample(16'd27898, 19'd23843);
        c.mc = 16'sd100;
        load_cal(c);
        send_sample(16'd12345, 19'd40000);
        c = typical_cal(2'd1, 0);
        c.ac4 = '0;
        load_cal(c);
        send_sample(16'd27898, 19'd47686);
        send_sample(16'hFFFF, 19'd0);
    endtask

    task automatic test_random(int items);
        for (int i = 0; i < items; i++) begin
            if (i % 100 == 0) begin
                if ($urandom_range(9) < 7) load_cal(typical_cal(2'($urandom_range(3)), 300));
                else load_cal(random_cal());
            end
            if ($urandom_range(9) < 8) send_typical();
            else send_sample(16'($urandom()), 19'($urandom()));
        end
    endtask

    initial begin
        cal = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_cal();
        test_typical_oss();
        test_extreme_cal();
        test_divide_by_zero();
        send_idle_pct = 25;
        recv_idle_pct = 58;
        test_random(400);
        send_idle_pct = 58;
        recv_idle_pct = 25;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        drain();
        if (fail_cnt == 0) begin
            $display("barometric_pressure_compensation verification clean");
        end else begin
            $display("barometric_pressure_compensation verification failed");
        end
        $finish;
    end

endmodule
